// ===== rtl/core/bbcf_pkg.sv =====
package bbcf_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int STIFF_W = 32;
  localparam int OUT_W   = 48;
  localparam int LEN_W   = COORD_W - 1;

  // Bond vectors and their squared lengths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SUM_W   = 2 * MAG_W;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 1;

  // Stretch deviations and force ratios
  localparam int DR_W    = ROOT_W + 2;
  localparam int DRMAG_W = ROOT_W + 1;
  localparam int NUM_W   = STIFF_W + DRMAG_W;
  localparam int FC_W    = OUT_W + FRAC_W + 1;
  localparam int FLO_W   = MAG_W;
  localparam int FHI_W   = FC_W - FLO_W;
  localparam int T_W     = FC_W + MAG_W - FRAC_W;
  localparam int D_W     = T_W + 2;

  // Energy
  localparam int E1_W    = NUM_W - FRAC_W;
  localparam int ELO_W   = E1_W / 2;
  localparam int EHI_W   = E1_W - ELO_W;
  localparam int E_W     = E1_W + DRMAG_W - FRAC_W;
  localparam int SATM_W  = T_W;

  // Pipeline depth: front end, root steps, two stages, quotient steps, back end
  localparam int FRONT_LAT = 3;
  localparam int MID_LAT   = 2;
  localparam int BACK_LAT  = 4;
  localparam int PIPE_LAT  = FRONT_LAT + ROOT_W + MID_LAT + NUM_W + BACK_LAT;

  typedef logic signed [OUT_W-1:0] out_t;

endpackage

// ===== rtl/core/bbcf_isqrt.sv =====
module bbcf_isqrt import bbcf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  // One root bit per stage, two radicand bits consumed per stage
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [REM_W-1:0]  rem_next [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];
  logic [SUM_W-1:0]  rad_q  [ROOT_W];
  logic [SUM_W-1:0]  rad_next [ROOT_W];

  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = radicand;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
      end
      cur         = {rem_in, rad_in[SUM_W-1 -: 2]};
      trial       = {1'b0, root_in, 2'b01};
      rad_next[k] = {rad_in[SUM_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_next[k]  = REM_W'(cur - trial);
        root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = REM_W'(cur);
        root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q  <= rem_next;
      root_q <= root_next;
      rad_q  <= rad_next;
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

// ===== rtl/core/bbcf_div.sv =====
module bbcf_div import bbcf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [NUM_W-1:0]  quo
);

  // Restoring division, one quotient bit per stage; the dividend shifts out
  // at the top while quotient bits shift in at the bottom
  logic [ROOT_W-1:0] rem_q [NUM_W];
  logic [ROOT_W-1:0] rem_next [NUM_W];
  logic [NUM_W-1:0]  nq_q [NUM_W];
  logic [NUM_W-1:0]  nq_next [NUM_W];
  logic [ROOT_W-1:0] den_q [NUM_W];
  logic [ROOT_W-1:0] den_next [NUM_W];

  always_comb begin
    logic [ROOT_W-1:0] rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [ROOT_W-1:0] den_in;
    logic [ROOT_W:0]   cur;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        rem_in = '0;
        nq_in  = num;
        den_in = den;
      end else begin
        rem_in = rem_q[k-1];
        nq_in  = nq_q[k-1];
        den_in = den_q[k-1];
      end
      cur         = {rem_in, nq_in[NUM_W-1]};
      den_next[k] = den_in;
      if (cur >= {1'b0, den_in}) begin
        rem_next[k] = ROOT_W'(cur - {1'b0, den_in});
        nq_next[k]  = {nq_in[NUM_W-2:0], 1'b1};
      end else begin
        rem_next[k] = ROOT_W'(cur);
        nq_next[k]  = {nq_in[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      nq_q  <= nq_next;
      den_q <= den_next;
    end
  end

  assign quo = nq_q[NUM_W-1];

endmodule

// ===== rtl/core/bond_bond_cross_force.sv =====
// Bond-bond cross-term force unit.
// Input channel (in_valid/in_ready): one bond per transfer, three atom
// positions in signed Q15.16, two rest lengths and the force constant.
// Output channel (out_valid/out_ready): forces on the three atoms and the
// energy in signed Q31.16, saturated, plus a degenerate flag; a bond with a
// zero-length vector returns all zeros with degenerate set.
// Throughput: one bond per cycle while the output is not stalled. The depth
// is set by the square root, one root bit per stage over 33 stages, and the
// divider, one quotient bit per stage over 66 stages, with multipliers at
// most about 33 by 34 bits per stage.
// The whole pipeline advances together; when the receiver stalls, the
// pipeline holds and one more bond is still taken into the skid register,
// after which in_ready drops until the output moves again.
// Reset (rst, synchronous) clears every valid bit, the skid register's included; the
// unit is ready for a transfer in the first cycle after reset.
module bond_bond_cross_force import bbcf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] pos_i_x,
  input  logic signed [COORD_W-1:0] pos_i_y,
  input  logic signed [COORD_W-1:0] pos_i_z,
  input  logic signed [COORD_W-1:0] pos_j_x,
  input  logic signed [COORD_W-1:0] pos_j_y,
  input  logic signed [COORD_W-1:0] pos_j_z,
  input  logic signed [COORD_W-1:0] pos_k_x,
  input  logic signed [COORD_W-1:0] pos_k_y,
  input  logic signed [COORD_W-1:0] pos_k_z,
  input  logic        [LEN_W-1:0]   rest_len_first,
  input  logic        [LEN_W-1:0]   rest_len_second,
  input  logic signed [STIFF_W-1:0] stiffness,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   force_i_x,
  output logic signed [OUT_W-1:0]   force_i_y,
  output logic signed [OUT_W-1:0]   force_i_z,
  output logic signed [OUT_W-1:0]   force_j_x,
  output logic signed [OUT_W-1:0]   force_j_y,
  output logic signed [OUT_W-1:0]   force_j_z,
  output logic signed [OUT_W-1:0]   force_k_x,
  output logic signed [OUT_W-1:0]   force_k_y,
  output logic signed [OUT_W-1:0]   force_k_z,
  output logic signed [OUT_W-1:0]   energy,
  output logic                      degenerate
);

  typedef struct packed {
    logic [2:0][COORD_W-1:0] pi;
    logic [2:0][COORD_W-1:0] pj;
    logic [2:0][COORD_W-1:0] pk;
    logic [LEN_W-1:0]        r1;
    logic [LEN_W-1:0]        r2;
    logic [STIFF_W-1:0]      fk;
  } item_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] amag;
    logic [2:0]            aneg;
    logic [2:0][MAG_W-1:0] bmag;
    logic [2:0]            bneg;
    logic [STIFF_W-1:0]    fkmag;
    logic                  fkneg;
    logic [LEN_W-1:0]      r1;
    logic [LEN_W-1:0]      r2;
    logic                  degen;
  } geo_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] amag;
    logic [2:0]            aneg;
    logic [2:0][MAG_W-1:0] bmag;
    logic [2:0]            bneg;
    logic                  n1;
    logic                  n2;
    logic                  en;
    logic [DRMAG_W-1:0]    drmag2;
    logic [NUM_W-1:0]      num2;
    logic                  degen;
  } side_t;

  // Saturate a sign-magnitude value to the output range
  function automatic out_t sat_out(input logic neg, input logic [SATM_W-1:0] m);
    logic [SATM_W-1:0] lim;
    out_t              r;
    lim = SATM_W'(1) << (OUT_W - 1);
    if (!neg) begin
      r = (m > lim - SATM_W'(1)) ? {1'b0, {(OUT_W-1){1'b1}}} : $signed(m[OUT_W-1:0]);
    end else begin
      r = (m > lim) ? {1'b1, {(OUT_W-1){1'b0}}} : $signed(-m[OUT_W-1:0]);
    end
    return r;
  endfunction

  // Saturate a two's complement value to the output range
  function automatic out_t sat_sig(input logic signed [D_W-1:0] d);
    logic signed [D_W-1:0] hi;
    logic signed [D_W-1:0] lo;
    out_t                  r;
    hi = {{(D_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo = {{(D_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    if (d > hi) begin
      r = hi[OUT_W-1:0];
    end else if (d < lo) begin
      r = lo[OUT_W-1:0];
    end else begin
      r = d[OUT_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input skid register and global advance
  // ---------------------------------------------------------------------
  logic                adv;
  logic                skid_valid;
  item_t               skid;
  item_t               in_item;
  item_t               entry;
  logic                entry_valid;
  logic [PIPE_LAT-1:0] vld;

  assign adv         = !out_valid || out_ready;
  assign in_ready    = !skid_valid;
  assign entry       = skid_valid ? skid : in_item;
  assign entry_valid = skid_valid || in_valid;

  always_comb begin
    in_item.pi = {pos_i_z, pos_i_y, pos_i_x};
    in_item.pj = {pos_j_z, pos_j_y, pos_j_x};
    in_item.pk = {pos_k_z, pos_k_y, pos_k_x};
    in_item.r1 = rest_len_first;
    in_item.r2 = rest_len_second;
    in_item.fk = stiffness;
  end

  // Park a transfer in the skid register while the pipeline holds
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (adv) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (!adv && in_valid && !skid_valid) begin
      skid <= in_item;
    end
  end

  // Valid bits travel alongside every stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], entry_valid};
    end
  end

  assign out_valid = vld[PIPE_LAT-1];

  // ---------------------------------------------------------------------
  // Stage 1: bond vectors a = ri - rj, b = rj - rk, as sign and magnitude;
  // flag a zero-length vector
  // ---------------------------------------------------------------------
  geo_t s1_geo;
  geo_t s1_next;

  always_comb begin
    logic signed [DIFF_W-1:0] da;
    logic signed [DIFF_W-1:0] db;
    s1_next = '0;
    for (int c = 0; c < 3; c++) begin
      da = DIFF_W'($signed(entry.pi[c])) - DIFF_W'($signed(entry.pj[c]));
      db = DIFF_W'($signed(entry.pj[c])) - DIFF_W'($signed(entry.pk[c]));
      s1_next.aneg[c] = da[DIFF_W-1];
      s1_next.bneg[c] = db[DIFF_W-1];
      s1_next.amag[c] = da[DIFF_W-1] ? MAG_W'(-da) : MAG_W'(da);
      s1_next.bmag[c] = db[DIFF_W-1] ? MAG_W'(-db) : MAG_W'(db);
    end
    s1_next.fkneg = entry.fk[STIFF_W-1];
    s1_next.fkmag = entry.fk[STIFF_W-1] ? -entry.fk : entry.fk;
    s1_next.r1    = entry.r1;
    s1_next.r2    = entry.r2;
    s1_next.degen = (s1_next.amag == '0) || (s1_next.bmag == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_geo <= s1_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: component squares
  // ---------------------------------------------------------------------
  geo_t                    s2_geo;
  logic [2:0][SUM_W-1:0]   s2_sqa;
  logic [2:0][SUM_W-1:0]   s2_sqb;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_geo <= s1_geo;
      for (int c = 0; c < 3; c++) begin
        s2_sqa[c] <= SUM_W'(s1_geo.amag[c] * s1_geo.amag[c]);
        s2_sqb[c] <= SUM_W'(s1_geo.bmag[c] * s1_geo.bmag[c]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: squared lengths
  // ---------------------------------------------------------------------
  geo_t             s3_geo;
  logic [SUM_W-1:0] s3_sa;
  logic [SUM_W-1:0] s3_sb;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_geo <= s2_geo;
      s3_sa  <= s2_sqa[0] + s2_sqa[1] + s2_sqa[2];
      s3_sb  <= s2_sqb[0] + s2_sqb[1] + s2_sqb[2];
    end
  end

  // ---------------------------------------------------------------------
  // Bond lengths: floor square roots, geometry held in step alongside
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] root_a;
  logic [ROOT_W-1:0] root_b;
  geo_t              sq_line [ROOT_W];

  bbcf_isqrt u_sqrt_a (.clk(clk), .en(adv), .radicand(s3_sa), .root(root_a));
  bbcf_isqrt u_sqrt_b (.clk(clk), .en(adv), .radicand(s3_sb), .root(root_b));

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_line[0] <= s3_geo;
      for (int k = 1; k < ROOT_W; k++) begin
        sq_line[k] <= sq_line[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: stretch deviations dr1 = al - r1, dr2 = bl - r2
  // ---------------------------------------------------------------------
  geo_t               d_geo;
  logic [ROOT_W-1:0]  d_al;
  logic [ROOT_W-1:0]  d_bl;
  logic [DRMAG_W-1:0] d_drmag1;
  logic [DRMAG_W-1:0] d_drmag2;
  logic               d_drneg1;
  logic               d_drneg2;

  always_ff @(posedge clk) begin
    logic signed [DR_W-1:0] dr1;
    logic signed [DR_W-1:0] dr2;
    dr1 = $signed(DR_W'(root_a)) - $signed(DR_W'(sq_line[ROOT_W-1].r1));
    dr2 = $signed(DR_W'(root_b)) - $signed(DR_W'(sq_line[ROOT_W-1].r2));
    if (adv) begin
      d_geo    <= sq_line[ROOT_W-1];
      d_al     <= root_a;
      d_bl     <= root_b;
      d_drneg1 <= dr1[DR_W-1];
      d_drneg2 <= dr2[DR_W-1];
      d_drmag1 <= dr1[DR_W-1] ? DRMAG_W'(-dr1) : DRMAG_W'(dr1);
      d_drmag2 <= dr2[DR_W-1] ? DRMAG_W'(-dr2) : DRMAG_W'(dr2);
    end
  end

  // ---------------------------------------------------------------------
  // Stage M: ratio numerators |fk*dr2|, |fk*dr1| and result signs
  // ---------------------------------------------------------------------
  side_t             m_side;
  logic [NUM_W-1:0]  m_num1;
  logic [ROOT_W-1:0] m_al;
  logic [ROOT_W-1:0] m_bl;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_num1        <= NUM_W'(d_geo.fkmag * d_drmag2);
      m_side.num2   <= NUM_W'(d_geo.fkmag * d_drmag1);
      m_al          <= d_al;
      m_bl          <= d_bl;
      m_side.amag   <= d_geo.amag;
      m_side.aneg   <= d_geo.aneg;
      m_side.bmag   <= d_geo.bmag;
      m_side.bneg   <= d_geo.bneg;
      m_side.n1     <= d_geo.fkneg ^ d_drneg2;
      m_side.n2     <= d_geo.fkneg ^ d_drneg1;
      m_side.en     <= d_geo.fkneg ^ d_drneg1 ^ d_drneg2;
      m_side.drmag2 <= d_drmag2;
      m_side.degen  <= d_geo.degen;
    end
  end

  // ---------------------------------------------------------------------
  // Force ratios fr1 = fk*dr2/al, fr2 = fk*dr1/bl
  // ---------------------------------------------------------------------
  logic [NUM_W-1:0] quo1;
  logic [NUM_W-1:0] quo2;
  side_t            dv_line [NUM_W];

  bbcf_div u_div_1 (.clk(clk), .en(adv), .num(m_num1), .den(m_al), .quo(quo1));
  bbcf_div u_div_2 (.clk(clk), .en(adv), .num(m_side.num2), .den(m_bl), .quo(quo2));

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_line[0] <= m_side;
      for (int k = 1; k < NUM_W; k++) begin
        dv_line[k] <= dv_line[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage Q: clamp ratios (any larger one saturates anyway), set signs
  // ---------------------------------------------------------------------
  side_t              dv_out;
  logic [FC_W-1:0]    q_f1;
  logic [FC_W-1:0]    q_f2;
  logic [2:0]         q_s1;
  logic [2:0]         q_s2;
  logic [2:0][MAG_W-1:0] q_amag;
  logic [2:0][MAG_W-1:0] q_bmag;
  logic [E1_W-1:0]    q_e1;
  logic [DRMAG_W-1:0] q_drmag2;
  logic               q_en;
  logic               q_degen;

  assign dv_out = dv_line[NUM_W-1];

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] lim;
    lim = NUM_W'(1) << (FC_W - 1);
    if (adv) begin
      q_f1     <= (quo1 > lim) ? FC_W'(lim) : FC_W'(quo1);
      q_f2     <= (quo2 > lim) ? FC_W'(lim) : FC_W'(quo2);
      q_s1     <= {3{dv_out.n1}} ^ dv_out.aneg;
      q_s2     <= {3{dv_out.n2}} ^ dv_out.bneg;
      q_amag   <= dv_out.amag;
      q_bmag   <= dv_out.bmag;
      q_e1     <= dv_out.num2[NUM_W-1:FRAC_W];
      q_drmag2 <= dv_out.drmag2;
      q_en     <= dv_out.en;
      q_degen  <= dv_out.degen;
    end
  end

  // ---------------------------------------------------------------------
  // Stage P: partial products of ratio times vector, and of the energy
  // ---------------------------------------------------------------------
  logic [2:0][FLO_W+MAG_W-1:0] p_alo;
  logic [2:0][FHI_W+MAG_W-1:0] p_ahi;
  logic [2:0][FLO_W+MAG_W-1:0] p_blo;
  logic [2:0][FHI_W+MAG_W-1:0] p_bhi;
  logic [ELO_W+DRMAG_W-1:0]    p_elo;
  logic [EHI_W+DRMAG_W-1:0]    p_ehi;
  logic [2:0]                  p_s1;
  logic [2:0]                  p_s2;
  logic                        p_en;
  logic                        p_degen;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p_alo[c] <= (FLO_W+MAG_W)'(q_f1[FLO_W-1:0] * q_amag[c]);
        p_ahi[c] <= (FHI_W+MAG_W)'(q_f1[FC_W-1:FLO_W] * q_amag[c]);
        p_blo[c] <= (FLO_W+MAG_W)'(q_f2[FLO_W-1:0] * q_bmag[c]);
        p_bhi[c] <= (FHI_W+MAG_W)'(q_f2[FC_W-1:FLO_W] * q_bmag[c]);
      end
      p_elo   <= (ELO_W+DRMAG_W)'(q_e1[ELO_W-1:0] * q_drmag2);
      p_ehi   <= (EHI_W+DRMAG_W)'(q_e1[E1_W-1:ELO_W] * q_drmag2);
      p_s1    <= q_s1;
      p_s2    <= q_s2;
      p_en    <= q_en;
      p_degen <= q_degen;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: combine partial products and drop the fraction bits
  // ---------------------------------------------------------------------
  logic [2:0][T_W-1:0] a_t1;
  logic [2:0][T_W-1:0] a_t2;
  logic [E_W-1:0]      a_e;
  logic [2:0]          a_s1;
  logic [2:0]          a_s2;
  logic                a_en;
  logic                a_degen;

  always_ff @(posedge clk) begin
    logic [FC_W+MAG_W-1:0]    fa;
    logic [FC_W+MAG_W-1:0]    fb;
    logic [E1_W+DRMAG_W-1:0]  fe;
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        fa = {p_ahi[c], {FLO_W{1'b0}}} + (FC_W+MAG_W)'(p_alo[c]);
        fb = {p_bhi[c], {FLO_W{1'b0}}} + (FC_W+MAG_W)'(p_blo[c]);
        a_t1[c] <= fa[FC_W+MAG_W-1:FRAC_W];
        a_t2[c] <= fb[FC_W+MAG_W-1:FRAC_W];
      end
      fe = {p_ehi, {ELO_W{1'b0}}} + (E1_W+DRMAG_W)'(p_elo);
      a_e     <= fe[E1_W+DRMAG_W-1:FRAC_W];
      a_s1    <= p_s1;
      a_s2    <= p_s2;
      a_en    <= p_en;
      a_degen <= p_degen;
    end
  end

  // ---------------------------------------------------------------------
  // Stage F: signs, middle-atom difference, saturation; output register
  // ---------------------------------------------------------------------
  out_t [2:0] f_i;
  out_t [2:0] f_j;
  out_t [2:0] f_k;
  out_t       f_e;
  logic       f_degen;

  always_ff @(posedge clk) begin
    logic signed [D_W-1:0] v1;
    logic signed [D_W-1:0] v2;
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        v1 = a_s1[c] ? -$signed(D_W'(a_t1[c])) : $signed(D_W'(a_t1[c]));
        v2 = a_s2[c] ? -$signed(D_W'(a_t2[c])) : $signed(D_W'(a_t2[c]));
        f_i[c] <= a_degen ? '0 : sat_out(!a_s1[c], a_t1[c]);
        f_j[c] <= a_degen ? '0 : sat_sig(v1 - v2);
        f_k[c] <= a_degen ? '0 : sat_out(a_s2[c], a_t2[c]);
      end
      f_e     <= a_degen ? '0 : sat_out(a_en, SATM_W'(a_e));
      f_degen <= a_degen;
    end
  end

  assign force_i_x  = f_i[0];
  assign force_i_y  = f_i[1];
  assign force_i_z  = f_i[2];
  assign force_j_x  = f_j[0];
  assign force_j_y  = f_j[1];
  assign force_j_z  = f_j[2];
  assign force_k_x  = f_k[0];
  assign force_k_y  = f_k[1];
  assign force_k_z  = f_k[2];
  assign energy     = f_e;
  assign degenerate = f_degen;

endmodule

// ===== rtl/core/bbcf_checker.sv =====
module bbcf_checker import bbcf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] force_i_x,
  input logic [OUT_W-1:0] force_i_y,
  input logic [OUT_W-1:0] force_i_z,
  input logic [OUT_W-1:0] force_j_x,
  input logic [OUT_W-1:0] force_j_y,
  input logic [OUT_W-1:0] force_j_z,
  input logic [OUT_W-1:0] force_k_x,
  input logic [OUT_W-1:0] force_k_y,
  input logic [OUT_W-1:0] force_k_z,
  input logic [OUT_W-1:0] energy,
  input logic             degenerate
);

  // Hold a stalled result: valid, energy and degenerate flag stay stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(energy) && $stable(degenerate))
    else $error("stalled result changed");

  // The skid register fills only while the output is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // Drain the skid register as soon as the pipeline advances
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    !in_ready && (out_ready || !out_valid) |=> in_ready)
    else $error("skid register not drained");

  // A degenerate bond returns all zeros
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> energy == '0 && force_i_x == '0 && force_i_y == '0 &&
      force_i_z == '0 && force_j_x == '0 && force_j_y == '0 && force_j_z == '0 &&
      force_k_x == '0 && force_k_y == '0 && force_k_z == '0)
    else $error("degenerate result not zeroed");

endmodule

bind bond_bond_cross_force bbcf_checker u_bbcf_checker (.*);

// ===== tb/sv/tb_bond_bond_cross_force.sv =====
`timescale 1ns / 100ps

module tb_bond_bond_cross_force;
  import bbcf_pkg::*;

  localparam int  N_RANDOM    = 1130;
  localparam int  DRAIN_WAIT  = PIPE_LAT + 20;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  NUM_FORCE   = 10;   // nine force components, then the energy

  typedef logic signed [159:0] wide_t;

  // One bond as it crosses the input channel
  typedef struct {
    logic signed [COORD_W-1:0] pos [9];   // i x/y/z, j x/y/z, k x/y/z
    logic        [LEN_W-1:0]   len1;
    logic        [LEN_W-1:0]   len2;
    logic signed [STIFF_W-1:0] fk;
  } bond_t;

  // One set of forces and energy as it leaves the block
  typedef struct {
    out_t val [NUM_FORCE];
    logic degen;
  } forces_t;

  // Holds the forces predicted for every bond in flight and compares them
  // against what the block returns, oldest first.
  class force_board;
    forces_t pending [$];
    int      n_errors;

    function wide_t magn(wide_t v);
      return (v < 0) ? -v : v;
    endfunction

    function wide_t isqrt(wide_t s);
      wide_t r, c;
      r = 0;
      for (int bitpos = 40; bitpos >= 0; bitpos--) begin
        c = r | (wide_t'(1) <<< bitpos);
        if (c * c <= s) r = c;
      end
      return r;
    endfunction

    function out_t clip(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (OUT_W - 1)) - 1;
      lo = -(wide_t'(1) <<< (OUT_W - 1));
      if (v > hi) return out_t'(hi);
      if (v < lo) return out_t'(lo);
      return out_t'(v);
    endfunction

    // Magnitude of fk*dr/len truncated, capped where every product saturates
    function wide_t force_ratio(wide_t fk, wide_t dr, wide_t len);
      wide_t q, cap;
      cap = wide_t'(1) <<< (48 + FRAC_W);
      q = (magn(fk) * magn(dr)) / len;
      return (q > cap) ? cap : q;
    endfunction

    // Work out the forces and energy of an accepted bond and queue them
    function void note_bond(bond_t bd);
      wide_t   p [9];
      wide_t   a [3], b [3];
      wide_t   sa, sb, al, bl, dr1, dr2, fk, q1, q2, t1, t2, v1, v2, e;
      logic    n1, n2, en;
      forces_t res;
      for (int c = 0; c < 9; c++) p[c] = wide_t'(bd.pos[c]);
      fk = wide_t'(bd.fk);
      sa = 0;
      sb = 0;
      for (int c = 0; c < 3; c++) begin
        a[c] = p[c] - p[3+c];
        b[c] = p[3+c] - p[6+c];
        sa += a[c] * a[c];
        sb += b[c] * b[c];
      end
      for (int c = 0; c < NUM_FORCE; c++) res.val[c] = '0;
      res.degen = 1'b1;
      if (sa != 0 && sb != 0) begin
        res.degen = 1'b0;
        al  = isqrt(sa);
        bl  = isqrt(sb);
        dr1 = al - wide_t'(bd.len1);
        dr2 = bl - wide_t'(bd.len2);
        q1  = force_ratio(fk, dr2, al);
        q2  = force_ratio(fk, dr1, bl);
        n1  = (fk < 0) ^ (dr2 < 0);
        n2  = (fk < 0) ^ (dr1 < 0);
        for (int c = 0; c < 3; c++) begin
          t1 = (q1 * magn(a[c])) >>> FRAC_W;
          t2 = (q2 * magn(b[c])) >>> FRAC_W;
          v1 = (n1 ^ (a[c] < 0)) ? -t1 : t1;
          v2 = (n2 ^ (b[c] < 0)) ? -t2 : t2;
          res.val[c]   = clip(-v1);
          res.val[3+c] = clip(v1 - v2);
          res.val[6+c] = clip(v2);
        end
        // truncate after each product, as the block does
        e  = (magn(fk) * magn(dr1)) >>> FRAC_W;
        e  = (e * magn(dr2)) >>> FRAC_W;
        en = (fk < 0) ^ (dr1 < 0) ^ (dr2 < 0);
        res.val[9] = clip(en ? -e : e);
      end
      pending.push_back(res);
    endfunction

    function void check_result(forces_t got);
      forces_t want;
      logic    bad;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      want = pending.pop_front();
      bad  = (want.degen !== got.degen);
      for (int c = 0; c < NUM_FORCE; c++) if (want.val[c] !== got.val[c]) bad = 1'b1;
      if (bad) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch at %0t, degenerate exp %0b got %0b",
                   $realtime, want.degen, got.degen);
          for (int c = 0; c < NUM_FORCE; c++)
            $display("  field %0d exp %0d got %0d", c, want.val[c], got.val[c]);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, degenerate;
  logic signed [COORD_W-1:0] pos [9];
  logic        [LEN_W-1:0]   rest_len_first, rest_len_second;
  logic signed [STIFF_W-1:0] stiffness;
  out_t force_o [NUM_FORCE];

  force_board board;
  int  send_idle_pct, recv_idle_pct;
  int  cycles;

  bond_bond_cross_force i_dut (
    .clk, .rst, .in_valid, .in_ready,
    .pos_i_x(pos[0]), .pos_i_y(pos[1]), .pos_i_z(pos[2]),
    .pos_j_x(pos[3]), .pos_j_y(pos[4]), .pos_j_z(pos[5]),
    .pos_k_x(pos[6]), .pos_k_y(pos[7]), .pos_k_z(pos[8]),
    .rest_len_first, .rest_len_second, .stiffness,
    .out_valid, .out_ready,
    .force_i_x(force_o[0]), .force_i_y(force_o[1]), .force_i_z(force_o[2]),
    .force_j_x(force_o[3]), .force_j_y(force_o[4]), .force_j_z(force_o[5]),
    .force_k_x(force_o[6]), .force_k_y(force_o[7]), .force_k_z(force_o[8]),
    .energy(force_o[9]), .degenerate
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bond_bond_cross_force failed");
      $finish;
    end
  end

  // Receiver: stall at random on the falling edge, check on the rising edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    forces_t got;
    if (!rst && out_valid && out_ready) begin
      for (int c = 0; c < NUM_FORCE; c++) got.val[c] = force_o[c];
      got.degen = degenerate;
      board.check_result(got);
    end
  end

  // Present one bond; hold it until the transfer, then note it.
  // Leave valid high afterwards so a back-to-back bond needs no dip.
  task automatic send_bond(bond_t bd);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    for (int c = 0; c < 9; c++) pos[c] = bd.pos[c];
    rest_len_first  = bd.len1;
    rest_len_second = bd.len2;
    stiffness       = bd.fk;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_bond(bd);
    @(negedge clk);
  endtask

  function automatic int small_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly physically sensible bonds, with full-range noise and collapsed bonds
  function automatic bond_t random_bond();
    bond_t bd;
    int    kind, span;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      for (int c = 0; c < 9; c++) bd.pos[c] = $urandom();
      bd.len1 = LEN_W'($urandom());
      bd.len2 = LEN_W'($urandom());
      bd.fk   = $urandom();
    end else begin
      span = ($urandom_range(0, 9) == 0) ? (1 << 28) : (1 << 18);
      for (int c = 0; c < 3; c++) begin
        bd.pos[3+c] = small_signed(1 << 22);
        bd.pos[c]   = bd.pos[3+c] + small_signed(span);
        bd.pos[6+c] = bd.pos[3+c] + small_signed(span);
      end
      if (kind < 26) for (int c = 0; c < 3; c++) bd.pos[c] = bd.pos[3+c];
      else if (kind < 32) for (int c = 0; c < 3; c++) bd.pos[6+c] = bd.pos[3+c];
      bd.len1 = LEN_W'($urandom_range(0, 1 << 19));
      bd.len2 = LEN_W'($urandom_range(0, 1 << 19));
      bd.fk   = small_signed(($urandom_range(0, 3) == 0) ? 32'h7fffffff : (1 << 24));
    end
    return bd;
  endfunction

  function automatic bond_t make_bond(int ix, int jx, int kx, int l1, int l2, int fk);
    bond_t bd;
    for (int c = 0; c < 9; c++) bd.pos[c] = '0;
    bd.pos[0] = ix;
    bd.pos[3] = jx;
    bd.pos[6] = kx;
    bd.len1 = LEN_W'(l1);
    bd.len2 = LEN_W'(l2);
    bd.fk   = fk;
    return bd;
  endfunction

  initial begin
    bond_t bd;
    localparam int ONE  = 1 << FRAC_W;
    localparam int PMAX = 32'h7fffffff;
    localparam int PMIN = 32'h80000000;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    for (int c = 0; c < 9; c++) pos[c] = '0;
    rest_len_first = '0;
    rest_len_second = '0;
    stiffness = '0;
    cycles = 0;
    send_idle_pct = 22;
    recv_idle_pct = 76;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: collapsed bonds, unit bonds, stretched and squeezed, extremes
    send_bond(make_bond(0, 0, 0, 0, 0, ONE));
    send_bond(make_bond(5 * ONE, 5 * ONE, 3 * ONE, ONE, ONE, ONE));
    send_bond(make_bond(2 * ONE, ONE, ONE, ONE, ONE, ONE));
    send_bond(make_bond(2 * ONE, 0, -ONE, ONE, ONE, ONE));
    send_bond(make_bond(3 * ONE, 0, -2 * ONE, ONE, ONE, 4 * ONE));
    send_bond(make_bond(ONE, 0, -ONE, 2 * ONE, 3 * ONE, -ONE));
    send_bond(make_bond(2 * ONE, 0, -3 * ONE, ONE, ONE, 0));
    send_bond(make_bond(PMAX, PMIN, PMAX, 0, 0, PMAX));
    send_bond(make_bond(PMAX, PMIN, PMAX, 0, 0, PMIN));
    send_bond(make_bond(PMIN, PMAX, PMIN, PMAX, PMAX, PMAX));
    send_bond(make_bond(1, 0, -1, PMAX, PMAX, PMIN));
    send_bond(make_bond(1, 0, 1, 0, 0, 1));
    send_bond(make_bond(-1, 0, 1, 0, 0, -1));
    bd = make_bond(ONE, 0, 0, ONE, ONE, 100 * ONE);
    bd.pos[7] = ONE;
    bd.pos[2] = -ONE;
    send_bond(bd);
    for (int c = 0; c < 9; c++) bd.pos[c] = (c % 2) ? PMAX : PMIN;
    bd.len1 = '1;
    bd.len2 = '0;
    send_bond(bd);

    // Let the pipeline empty before the random traffic starts
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 22;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_bond(random_bond());
    end
    in_valid = 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (board.n_errors == 0) $display("tb_bond_bond_cross_force passed");
    else                     $display("tb_bond_bond_cross_force failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bbcf_pkg.sv
rtl/core/bbcf_isqrt.sv
rtl/core/bbcf_div.sv
rtl/core/bond_bond_cross_force.sv
rtl/core/bbcf_checker.sv
tb/sv/tb_bond_bond_cross_force.sv
